// ----- rtl/route_order_crossover_mutate_assert.svh -----
// Assertion macros for the route crossover block.
// Depends on nothing; taken in by the modules that carry assertions.
`ifndef ROUTE_ORDER_CROSSOVER_MUTATE_ASSERT_SVH
`define ROUTE_ORDER_CROSSOVER_MUTATE_ASSERT_SVH

// same-cycle implication
`define ROC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("route_order_crossover_mutate: assertion failed");

// next-cycle implication
`define ROC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("route_order_crossover_mutate: assertion failed");

`endif

// ----- rtl/roc_pkg.sv -----
// Shared widths, command codes and controller/datapath structs for the route crossover.
// No dependencies.
package roc_pkg;

	localparam int CMD_W      = 2;
	localparam int POS_W      = 6;
	localparam int NODE_W     = 6;
	localparam int LEN_W      = 7;
	localparam int NODE_SLOTS = 64;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
	localparam logic [LEN_W-1:0] LEN_MIN   = 7'd4;

	localparam logic [CMD_W-1:0] CMD_LOAD_ONE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_TWO = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BUILD    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic latch;
		logic setup;
		logic seg_write;
		logic i_inc;
		logic fill_init;
		logic fill_adv;
		logic fill_write;
		logic out_init;
		logic out_load;
	} roc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_build;
		logic seg_last;
		logic taken;
		logic fill_full;
		logic fill_busy;
		logic scan_last;
		logic out_last;
		logic out_free;
	} roc_sts_t;

endpackage

// ----- rtl/roc_ifs.sv -----
// Channel interfaces: build/load items in, child elements out, route length writes.
// Depends on roc_pkg.
interface roc_in_if import roc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [POS_W-1:0]  position;
	logic [NODE_W-1:0] node;
	logic [POS_W-1:0]  seg_start;
	logic [POS_W-1:0]  seg_end;
	logic              do_swap;
	logic [POS_W-1:0]  swap_a;
	logic [POS_W-1:0]  swap_b;

	modport source (output valid, command, position, node, seg_start, seg_end,
		do_swap, swap_a, swap_b, input ready);
	modport sink (input valid, command, position, node, seg_start, seg_end,
		do_swap, swap_a, swap_b, output ready);
endinterface

interface roc_out_if import roc_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] child_node;
	logic [POS_W-1:0]  child_position;
	logic              last;

	modport source (output valid, child_node, child_position, last, input ready);
	modport sink (input valid, child_node, child_position, last, output ready);
endinterface

interface roc_cfg_if import roc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/route_order_crossover_mutate.sv -----
// Ordered crossover with swap mutation for depot-bounded routes.
// Channels: item (sink) takes load and build transactions; child (source) gives
// one transaction per child element, last marking the final one; cfg (sink)
// writes route_length, always ready, to be written only while the block is idle.
// A load transaction is taken while the block is idle and gives nothing out.
// A build copies the segment from parent one, fills the remaining inner slots
// from parent two in order (skipping occupied slots), then emits each element in
// turn. Each memory has a single registered read port: every step is a read
// followed by a use.
// item is not ready from a build transaction until its last element is in the
// output register; the output register lets a new transaction in while the final
// element waits. A stalled receiver holds the sequencer at the next element.
// Reset: route_length returns to 64, marks and handshakes clear; parent and
// child stores keep whatever they held.
// Depends on roc_pkg, roc_ifs, roc_ctrl and roc_dp.
module route_order_crossover_mutate import roc_pkg::*; #(
	parameter int MAX_ROUTE = 64
) (
	input logic         clk,
	input logic         arst_n,
	roc_in_if.sink      item,
	roc_out_if.source   child,
	roc_cfg_if.sink     cfg
);

	localparam int DEPTH = (MAX_ROUTE < 64) ? MAX_ROUTE : 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	roc_cmd_t cmd;
	roc_sts_t sts;

	assign cfg.ready = 1'b1;

	roc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	roc_dp #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.command        (item.command),
		.position       (item.position),
		.node           (item.node),
		.seg_start      (item.seg_start),
		.seg_end        (item.seg_end),
		.do_swap        (item.do_swap),
		.swap_a         (item.swap_a),
		.swap_b         (item.swap_b),
		.cfg_valid      (cfg.valid),
		.cfg_data       (cfg.data),
		.out_valid      (child.valid),
		.out_ready      (child.ready),
		.child_node     (child.child_node),
		.child_position (child.child_position),
		.last           (child.last)
	);

endmodule

// ----- rtl/roc_ctrl.sv -----
// Sequencer for the route crossover: load, segment copy, parent-two fill, emit.
// Depends on roc_pkg; drives the datapath through roc_cmd_t.
module roc_ctrl import roc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  roc_sts_t sts,
	output roc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SETUP   = 3'd1;
	localparam logic [2:0] ST_SEG_RD  = 3'd2;
	localparam logic [2:0] ST_SEG_WR  = 3'd3;
	localparam logic [2:0] ST_FIL_RD  = 3'd4;
	localparam logic [2:0] ST_FIL_CHK = 3'd5;
	localparam logic [2:0] ST_OUT_RD  = 3'd6;
	localparam logic [2:0] ST_OUT_LD  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		state_nxt  = state_q;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (sts.is_build) begin
						cmd.latch = 1'b1;
						state_nxt = ST_SETUP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = ST_SEG_RD;
			end
			ST_SEG_RD: state_nxt = ST_SEG_WR;
			ST_SEG_WR: begin
				cmd.seg_write = 1'b1;
				if (sts.seg_last) begin
					cmd.fill_init = 1'b1;
					state_nxt     = ST_FIL_RD;
				end else begin
					cmd.i_inc = 1'b1;
					state_nxt = ST_SEG_RD;
				end
			end
			ST_FIL_RD: state_nxt = ST_FIL_CHK;
			ST_FIL_CHK: begin
				if (!sts.taken && sts.fill_full) begin
					// no free inner slot left: remaining parent-two nodes dropped
					cmd.out_init = 1'b1;
					state_nxt    = ST_OUT_RD;
				end else if (!sts.taken && sts.fill_busy) begin
					cmd.fill_adv = 1'b1;
				end else begin
					cmd.fill_write = !sts.taken;
					if (sts.scan_last) begin
						cmd.out_init = 1'b1;
						state_nxt    = ST_OUT_RD;
					end else begin
						cmd.i_inc = 1'b1;
						state_nxt = ST_FIL_RD;
					end
				end
			end
			ST_OUT_RD: state_nxt = ST_OUT_LD;
			ST_OUT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.out_last) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.i_inc = 1'b1;
						state_nxt = ST_OUT_RD;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/roc_dp.sv -----
// Datapath for the route crossover: parent and child memories, marks, counters,
// range saturation and the output register. Depends on roc_pkg and the assert macros.
`include "route_order_crossover_mutate_assert.svh"

module roc_dp import roc_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  roc_cmd_t          cmd,
	output roc_sts_t          sts,
	input  logic [CMD_W-1:0]  command,
	input  logic [POS_W-1:0]  position,
	input  logic [NODE_W-1:0] node,
	input  logic [POS_W-1:0]  seg_start,
	input  logic [POS_W-1:0]  seg_end,
	input  logic              do_swap,
	input  logic [POS_W-1:0]  swap_a,
	input  logic [POS_W-1:0]  swap_b,
	input  logic              cfg_valid,
	input  logic [LEN_W-1:0]  cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] child_node,
	output logic [POS_W-1:0]  child_position,
	output logic              last
);

	localparam logic [LEN_W-1:0] LEN_HI = LEN_W'(DEPTH);

	function automatic logic [LEN_W-1:0] clamp7(input logic [LEN_W-1:0] v,
		input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
		logic [LEN_W-1:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	logic [LEN_W-1:0]      rl_q;
	logic [LEN_W-1:0]      n_q;
	logic [POS_W-1:0]      seg_start_q, seg_end_q, swap_a_q, swap_b_q;
	logic                  swap_q;
	logic [POS_W-1:0]      start_q, end_q, a_q, b_q;
	logic [POS_W-1:0]      i_q, fill_q;
	logic [DEPTH-1:0]      filled_q;
	logic [NODE_SLOTS-1:0] taken_q;

	logic [NODE_W-1:0] p1_mem [DEPTH];
	logic [NODE_W-1:0] p2_mem [DEPTH];
	logic [NODE_W-1:0] child_mem [DEPTH];
	logic [NODE_W-1:0] rd_p1_q, rd_p2_q, rd_child_q;
	logic              rd_filled_q;

	logic              out_valid_q, out_last_q;
	logic [NODE_W-1:0] out_node_q;
	logic [POS_W-1:0]  out_pos_q;

	logic [LEN_W-1:0]  n_c, start_c, end_c, a_c, b_c;
	logic              load_ok;
	logic [POS_W-1:0]  rd_pos;
	logic              child_we;
	logic [POS_W-1:0]  child_wa;
	logic [NODE_W-1:0] child_wd;

	always_comb begin
		n_c     = clamp7(rl_q, LEN_MIN, LEN_HI);
		start_c = clamp7({1'b0, seg_start_q}, 7'd1, n_q - 7'd3);
		end_c   = clamp7({1'b0, seg_end_q}, start_c, n_q - 7'd2);
		a_c     = clamp7({1'b0, swap_a_q}, 7'd1, n_q - 7'd2);
		b_c     = clamp7({1'b0, swap_b_q}, 7'd1, n_q - 7'd2);
	end

	assign load_ok = cmd.load && ({1'b0, position} < LEN_HI);

	// swap applied as an address remap on the way out
	always_comb begin
		if (swap_q && (i_q == a_q)) rd_pos = b_q;
		else if (swap_q && (i_q == b_q)) rd_pos = a_q;
		else rd_pos = i_q;
	end

	assign child_we = cmd.seg_write || cmd.fill_write;
	assign child_wa = cmd.seg_write ? i_q : fill_q;
	assign child_wd = cmd.seg_write ? rd_p1_q : rd_p2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q <= LEN_RESET;
		end else if (cfg_valid) begin
			rl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			n_q         <= n_c;
			seg_start_q <= seg_start;
			seg_end_q   <= seg_end;
			swap_q      <= do_swap;
			swap_a_q    <= swap_a;
			swap_b_q    <= swap_b;
		end
		if (cmd.setup) begin
			start_q <= start_c[POS_W-1:0];
			end_q   <= end_c[POS_W-1:0];
			a_q     <= a_c[POS_W-1:0];
			b_q     <= b_c[POS_W-1:0];
		end
		if (cmd.setup) i_q <= start_c[POS_W-1:0];
		else if (cmd.fill_init) i_q <= POS_W'(1);
		else if (cmd.out_init) i_q <= '0;
		else if (cmd.i_inc) i_q <= i_q + POS_W'(1);
		if (cmd.fill_init) fill_q <= POS_W'(1);
		else if (cmd.fill_adv) fill_q <= fill_q + POS_W'(1);
	end

	// marks: flop vectors, cleared at the start of every build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			taken_q  <= '0;
		end else if (cmd.setup) begin
			filled_q <= '0;
			taken_q  <= '0;
		end else if (child_we) begin
			filled_q[child_wa[AW-1:0]] <= 1'b1;
			taken_q[child_wd]          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && (command == CMD_LOAD_ONE)) p1_mem[position[AW-1:0]] <= node;
		rd_p1_q <= p1_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (load_ok && (command == CMD_LOAD_TWO)) p2_mem[position[AW-1:0]] <= node;
		rd_p2_q <= p2_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa[AW-1:0]] <= child_wd;
		rd_child_q  <= child_mem[rd_pos[AW-1:0]];
		rd_filled_q <= filled_q[rd_pos[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			// unfilled positions (depots, dropped slots) read as node 0
			out_node_q <= rd_filled_q ? rd_child_q : '0;
			out_pos_q  <= i_q;
			out_last_q <= sts.out_last;
		end
	end

	always_comb begin
		sts.is_build  = (command == CMD_BUILD);
		sts.seg_last  = (i_q == end_q);
		sts.taken     = taken_q[rd_p2_q];
		sts.fill_full = ({1'b0, fill_q} + 7'd1) >= n_q;
		sts.fill_busy = filled_q[fill_q[AW-1:0]];
		sts.scan_last = ({1'b0, i_q} + 7'd2) >= n_q;
		sts.out_last  = ({1'b0, i_q} + 7'd1) == n_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign child_node     = out_node_q;
	assign child_position = out_pos_q;
	assign last           = out_last_q;

	`ROC_ASSERT_IMP(a_fill_free, clk, arst_n, cmd.fill_write, !filled_q[fill_q[AW-1:0]] && !taken_q[rd_p2_q])
	`ROC_ASSERT_IMP(a_seg_range, clk, arst_n, cmd.seg_write, (i_q >= start_q) && (i_q <= end_q))
	`ROC_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	`ROC_ASSERT_NXT(a_setup_clears, clk, arst_n, cmd.setup, (filled_q == '0) && (taken_q == '0))

endmodule
